FILE: hw/rtl/nqsc_pkg.sv
`default_nettype none

package nqsc_pkg;

   // field widths fixed by the interface
   localparam int BOARD_W  = 5;
   localparam int COLUMN_W = 4;
   localparam int COUNT_W  = 24;

   localparam logic [BOARD_W-1:0] BOARD_RESET = 5'd8;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

   typedef logic [COUNT_W-1:0] count_type;

   // status from the search engine back to the top level
   typedef struct packed {
      logic      done;
      count_type count;
   } search_result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/nqsc_search.sv
`default_nettype none

module nqsc_search
   import nqsc_pkg::*;
#(
   parameter int MAX_BOARD = 16,
   localparam int N_W      = $clog2(MAX_BOARD + 1),
   localparam int ROW_W    = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [N_W-1:0]    size,
   input  wire logic [COLUMN_W-1:0] first,
   output search_result_type      result
);

   typedef logic [MAX_BOARD-1:0] mask_type;

   typedef struct packed {
      mask_type cols;
      mask_type rise;
      mask_type fall;
      mask_type pend;
   } record_type;

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type        state_ff;
   logic [N_W-1:0]   n_ff;
   mask_type         full_ff;
   record_type       cur_ff;
   logic [ROW_W-1:0] row_ff;
   count_type        count_ff;
   logic             done_ff;
   record_type       stack_ff [MAX_BOARD];

   mask_type   full_in;
   mask_type   start_bit;
   record_type start_rec;
   mask_type   pick;
   mask_type   pend_in;
   record_type child_in;
   logic       last_row;

   // board mask and first-row queen
   always_comb begin
      for (int i = 0; i < MAX_BOARD; i++) begin
         full_in[i]   = (i < int'(size));
         start_bit[i] = (int'(first) == i);
      end
      start_rec.cols = start_bit;
      start_rec.rise = (start_bit << 1) & full_in;
      start_rec.fall = start_bit >> 1;
      start_rec.pend = full_in & ~(start_rec.cols | start_rec.rise | start_rec.fall);
   end

   // shared step unit: lowest pending column, and the record of the row below
   always_comb begin
      pick          = cur_ff.pend & (~cur_ff.pend + MAX_BOARD'(1));
      pend_in       = cur_ff.pend ^ pick;
      child_in.cols = cur_ff.cols | pick;
      child_in.rise = ((cur_ff.rise | pick) << 1) & full_ff;
      child_in.fall = (cur_ff.fall | pick) >> 1;
      child_in.pend = full_ff & ~(child_in.cols | child_in.rise | child_in.fall);
      last_row      = ((N_W'(row_ff) + N_W'(1)) == n_ff);
   end

   // sequencer: one placement or one backtrack per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  n_ff    <= size;
                  full_ff <= full_in;
                  if (size == N_W'(1)) begin
                     count_ff <= COUNT_W'(1);
                     done_ff  <= 1'b1;
                  end else begin
                     count_ff <= '0;
                     cur_ff   <= start_rec;
                     row_ff   <= ROW_W'(1);
                     state_ff <= RUN;
                  end
               end
            end
            RUN: begin
               if (cur_ff.pend == '0) begin
                  if (row_ff == ROW_W'(1)) begin
                     done_ff  <= 1'b1;
                     state_ff <= IDLE;
                  end else begin
                     cur_ff <= stack_ff[row_ff - ROW_W'(1)];
                     row_ff <= row_ff - ROW_W'(1);
                  end
               end else if (last_row) begin
                  cur_ff.pend <= pend_in;
                  if (count_ff != COUNT_MAX) begin
                     count_ff <= count_ff + COUNT_W'(1);
                  end
               end else begin
                  stack_ff[row_ff] <= '{cols: cur_ff.cols, rise: cur_ff.rise,
                                        fall: cur_ff.fall, pend: pend_in};
                  cur_ff <= child_in;
                  row_ff <= row_ff + ROW_W'(1);
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign result = '{done: done_ff, count: count_ff};

`ifndef SYNTHESIS
   // the row under search stays between the second row and the last
   assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |-> row_ff >= ROW_W'(1) && (N_W'(row_ff) < n_ff))
      else $error("search row out of range");

   // pending columns never fall off the board in use
   assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |-> (cur_ff.pend & ~full_ff) == '0)
      else $error("pending column beyond board size");

   // the count only grows during a search
   assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |=> count_ff >= $past(count_ff))
      else $error("solution count decreased during search");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/n_queens_solution_counter.sv
`default_nettype none

// N-queens solution counter
//
// A request transfer on req_ carries the column of the queen in the first row.
// The block counts every placement of board_size non-attacking queens with
// that first queen and answers with one transfer on rsp_: the count for the
// column, the running total since reset and bad_column. Both counts saturate.
// A column at or beyond the board size answers 0 with bad_column set, total
// unchanged.
// The search is depth first with one step a cycle: each placement tried and
// each backtrack is one step of the shared step unit. One request is in work
// at a time; req_stall is high from transfer until the result enters the
// output register, which may still hold an earlier result the receiver has
// not taken. While rsp_stall is high the result holds; a finished search
// waits for it. Reset clears the running total, empties the output and sets
// the board size to 8. The board size is written through csr_; the user must
// do so only while the block is idle, as the block itself does not enforce
// it.

module n_queens_solution_counter
   import nqsc_pkg::*;
#(
   parameter int MAX_BOARD = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [COLUMN_W-1:0] req_first_column,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [COUNT_W-1:0]       rsp_column_solutions,
   output logic [COUNT_W-1:0]       rsp_running_total,
   output logic                     rsp_bad_column,
   input  wire logic                csr_write_enable,
   input  wire logic [BOARD_W-1:0]  csr_write_data
);

   localparam int N_W = $clog2(MAX_BOARD + 1);

   typedef enum logic [1:0] {
      IDLE,
      SEARCH,
      DELIVER
   } state_type;

   state_type         state_ff;
   logic [BOARD_W-1:0] board_size_ff;
   count_type         result_count_ff;
   logic              result_bad_ff;
   count_type         running_total_ff;
   logic              rsp_valid_ff;
   count_type         rsp_column_solutions_ff;
   count_type         rsp_running_total_ff;
   logic              rsp_bad_column_ff;

   logic [N_W-1:0]    size_in;
   logic              bad_in;
   logic              req_xfer;
   logic              rsp_xfer;
   logic              out_free;
   logic [COUNT_W:0]  sum_in;
   count_type         total_in;
   search_result_type search_result;

   // board size in use saturates at the largest board built
   always_comb begin
      if (int'(board_size_ff) > MAX_BOARD) begin
         size_in = N_W'(MAX_BOARD);
      end else begin
         size_in = N_W'(board_size_ff);
      end
      bad_in = (int'(req_first_column) >= int'(size_in));
   end

   // handshakes
   assign req_stall = (state_ff != IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // saturating running total
   always_comb begin
      sum_in = {1'b0, running_total_ff} + {1'b0, result_count_ff};
      if (sum_in[COUNT_W]) begin
         total_in = COUNT_MAX;
      end else begin
         total_in = sum_in[COUNT_W-1:0];
      end
   end

   // board size register
   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff <= BOARD_RESET;
      end else if (csr_write_enable) begin
         board_size_ff <= csr_write_data;
      end
   end

   nqsc_search #(
      .MAX_BOARD (MAX_BOARD)
   ) u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (req_xfer && !bad_in),
      .size   (size_in),
      .first  (req_first_column),
      .result (search_result)
   );

   // request sequencing and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= IDLE;
         running_total_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // output empties on a transfer unless a new result moves in
         if (rsp_xfer && state_ff != DELIVER) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_xfer) begin
                  if (bad_in) begin
                     result_count_ff <= '0;
                     result_bad_ff   <= 1'b1;
                     state_ff        <= DELIVER;
                  end else begin
                     state_ff <= SEARCH;
                  end
               end
            end
            SEARCH: begin
               if (search_result.done) begin
                  result_count_ff <= search_result.count;
                  result_bad_ff   <= 1'b0;
                  state_ff        <= DELIVER;
               end
            end
            DELIVER: begin
               if (out_free) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_column_solutions_ff <= result_count_ff;
                  rsp_bad_column_ff       <= result_bad_ff;
                  rsp_running_total_ff    <= total_in;
                  running_total_ff        <= total_in;
                  state_ff                <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_column_solutions = rsp_column_solutions_ff;
   assign rsp_running_total    = rsp_running_total_ff;
   assign rsp_bad_column       = rsp_bad_column_ff;

`ifndef SYNTHESIS
   // a rejected column never reports solutions
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_column |-> rsp_column_solutions == '0)
      else $error("bad column result with nonzero count");

   // the running total never goes down
   assert property (@(posedge clock) disable iff (reset)
      !reset |=> running_total_ff >= $past(running_total_ff))
      else $error("running total decreased");

   // the search only finishes while a request is under search
   assert property (@(posedge clock) disable iff (reset)
      search_result.done |-> state_ff == SEARCH)
      else $error("search finished with no request in work");

   // an accepted request always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == SEARCH || state_ff == DELIVER)
      else $error("request transfer without search or delivery");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nqsc_pkg::*;

   localparam int MAX_BOARD    = 16;
   localparam int RANDOM_ROUNDS = 10;
   localparam int ROUND_ITEMS  = 10;
   localparam int QUIET_ROUND  = 3;
   localparam int HOLD_ROUND   = 6;
   localparam int HOLD_CYCLES  = 600;
   localparam int PLAN_LEN     = 30;

   typedef enum logic [1:0] {SET_SIZE, ASK_PREDICTED, ASK_KNOWN} step_kind_type;

   typedef struct packed {
      step_kind_type      kind;
      logic [BOARD_W-1:0] value;
      count_type          solutions;
      logic               bad;
   } plan_step_type;

   typedef struct packed {
      count_type solutions;
      count_type total;
      logic      bad;
   } column_answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [COLUMN_W-1:0] req_first_column = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COUNT_W-1:0]  rsp_column_solutions;
   logic [COUNT_W-1:0]  rsp_running_total;
   logic                rsp_bad_column;
   logic                csr_write_enable = 1'b0;
   logic [BOARD_W-1:0]  csr_write_data = '0;

   // shared between stimulus and checking
   column_answer_type   awaited_answers [$];
   logic [BOARD_W-1:0]  size_model;
   count_type           total_model;
   logic                quiet = 1'b0;
   logic                hold_rsp = 1'b0;
   logic                hold_wanted = 1'b0;
   int                  mismatches = 0;
   int                  answers_checked = 0;
   int                  columns_sent = 0;
   int                  off_board_sent = 0;
   plan_step_type       plan [PLAN_LEN];

   n_queens_solution_counter #(
      .MAX_BOARD(MAX_BOARD)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_first_column    (req_first_column),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_column_solutions(rsp_column_solutions),
      .rsp_running_total   (rsp_running_total),
      .rsp_bad_column      (rsp_bad_column),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // depth-first count of placements with the row 0 queen in column first
   function automatic count_type count_placements(input int n, input int first);
      logic [31:0] col_mask [MAX_BOARD];
      logic [31:0] rise_mask [MAX_BOARD];
      logic [31:0] fall_mask [MAX_BOARD];
      logic [31:0] free_mask [MAX_BOARD];
      logic [31:0] full;
      logic [31:0] pick;
      logic [31:0] avail;
      logic [31:0] c;
      logic [31:0] r;
      logic [31:0] f;
      int          row;
      count_type   found;
      if (n == 1)
         return count_type'(1);
      full = (32'd1 << n) - 32'd1;
      pick = 32'd1 << first;
      row = 1;
      col_mask[1]  = pick;
      rise_mask[1] = (pick << 1) & full;
      fall_mask[1] = pick >> 1;
      free_mask[1] = full & ~(col_mask[1] | rise_mask[1] | fall_mask[1]);
      found = '0;
      while (row >= 1) begin
         avail = free_mask[row];
         if (avail == 32'd0) begin
            row--;
         end else begin
            // lowest free column first
            pick = avail & (~avail + 32'd1);
            free_mask[row] = avail ^ pick;
            if (row == n - 1) begin
               if (found != COUNT_MAX)
                  found++;
            end else begin
               c = col_mask[row] | pick;
               r = ((rise_mask[row] | pick) << 1) & full;
               f = (fall_mask[row] | pick) >> 1;
               row++;
               col_mask[row]  = c;
               rise_mask[row] = r;
               fall_mask[row] = f;
               free_mask[row] = full & ~(c | r | f);
            end
         end
      end
      return found;
   endfunction

   // answer for one column under the current size, advancing the total
   function automatic column_answer_type answer_for(input logic [COLUMN_W-1:0] col);
      column_answer_type  a;
      int                 n;
      count_type          found;
      logic [COUNT_W:0]   sum;
      n = (int'(size_model) > MAX_BOARD) ? MAX_BOARD : int'(size_model);
      if (int'(col) >= n) begin
         a.solutions = '0;
         a.total     = total_model;
         a.bad       = 1'b1;
      end else begin
         found = count_placements(n, int'(col));
         sum = {1'b0, total_model} + {1'b0, found};
         total_model = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
         a.solutions = found;
         a.total     = total_model;
         a.bad       = 1'b0;
      end
      return a;
   endfunction

   // wait for every answer, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_size(input logic [BOARD_W-1:0] value);
      drain();
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      size_model = value;
   endtask

   // offer one column and record its answer once the transfer happens
   task automatic offer_column(input logic [COLUMN_W-1:0] col, input step_kind_type kind,
                               input count_type known_solutions, input logic known_bad);
      column_answer_type a;
      while (!quiet && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_first_column <= col;
      do @(posedge clock); while (req_stall);
      a = answer_for(col);
      if (kind == ASK_KNOWN) begin
         a.solutions = known_solutions;
         a.bad       = known_bad;
      end
      if (a.bad)
         off_board_sent++;
      columns_sent++;
      awaited_answers.push_back(a);
   endtask

   // receiver: random stalls, plus the long hold-off
   always @(posedge clock) begin : answer_check
      column_answer_type seen;
      column_answer_type wanted;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_column_solutions, rsp_running_total, rsp_bad_column};
            if (awaited_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected answer: solutions %0d total %0d bad %0b",
                           seen.solutions, seen.total, seen.bad);
            end else begin
               wanted = awaited_answers.pop_front();
               answers_checked++;
               if (seen !== wanted) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected solutions %0d total %0d bad %0b, got %0d %0d %0b",
                              wanted.solutions, wanted.total, wanted.bad,
                              seen.solutions, seen.total, seen.bad);
               end
            end
         end
         rsp_stall <= hold_rsp || (!quiet && $urandom_range(99) < 15);
      end
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      wait (hold_wanted);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #200ms;
      $display("timed out with %0d answers outstanding", awaited_answers.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      logic [BOARD_W-1:0]  size;
      logic [COLUMN_W-1:0] col;
      int                  n;
      size_model  = BOARD_RESET;
      total_model = '0;
      // directed: reset size, off-board columns, tiny boards, size extremes
      plan = '{
         '{ASK_KNOWN,     5'd0,  24'd4,  1'b0},
         '{ASK_KNOWN,     5'd7,  24'd4,  1'b0},
         '{ASK_KNOWN,     5'd3,  24'd18, 1'b0},
         '{ASK_KNOWN,     5'd8,  24'd0,  1'b1},
         '{ASK_KNOWN,     5'd15, 24'd0,  1'b1},
         '{SET_SIZE,      5'd1,  24'd0,  1'b0},
         '{ASK_KNOWN,     5'd0,  24'd1,  1'b0},
         '{ASK_KNOWN,     5'd1,  24'd0,  1'b1},
         '{SET_SIZE,      5'd0,  24'd0,  1'b0},
         '{ASK_KNOWN,     5'd0,  24'd0,  1'b1},
         '{ASK_KNOWN,     5'd10, 24'd0,  1'b1},
         '{ASK_KNOWN,     5'd5,  24'd0,  1'b1},
         '{SET_SIZE,      5'd2,  24'd0,  1'b0},
         '{ASK_KNOWN,     5'd1,  24'd0,  1'b0},
         '{SET_SIZE,      5'd3,  24'd0,  1'b0},
         '{ASK_KNOWN,     5'd0,  24'd0,  1'b0},
         '{ASK_KNOWN,     5'd2,  24'd0,  1'b0},
         '{SET_SIZE,      5'd4,  24'd0,  1'b0},
         '{ASK_KNOWN,     5'd1,  24'd1,  1'b0},
         '{ASK_KNOWN,     5'd0,  24'd0,  1'b0},
         '{SET_SIZE,      5'd16, 24'd0,  1'b0},
         '{SET_SIZE,      5'd31, 24'd0,  1'b0},
         '{SET_SIZE,      5'd6,  24'd0,  1'b0},
         '{ASK_PREDICTED, 5'd2,  24'd0,  1'b0},
         '{ASK_KNOWN,     5'd6,  24'd0,  1'b1},
         '{SET_SIZE,      5'd12, 24'd0,  1'b0},
         '{ASK_PREDICTED, 5'd0,  24'd0,  1'b0},
         '{SET_SIZE,      5'd10, 24'd0,  1'b0},
         '{ASK_PREDICTED, 5'd9,  24'd0,  1'b0},
         '{ASK_PREDICTED, 5'd4,  24'd0,  1'b0}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // the largest boards are only written: a full 16 x 16 search runs far too long
      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].kind == SET_SIZE)
            write_size(plan[i].value);
         else
            offer_column(plan[i].value[COLUMN_W-1:0], plan[i].kind,
                         plan[i].solutions, plan[i].bad);
      end
      // random rounds: one board size each, mostly columns on the board
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         size = BOARD_W'($urandom_range(9, 0));
         if ($urandom_range(9) == 0)
            size = 5'd10;
         if (round == HOLD_ROUND)
            size = 5'd5;
         write_size(size);
         quiet <= (round == QUIET_ROUND);
         if (round == HOLD_ROUND)
            hold_wanted = 1'b1;
         n = int'(size);
         for (int k = 0; k < ROUND_ITEMS; k++) begin
            if (n == 0 || $urandom_range(99) < 20)
               col = COLUMN_W'($urandom_range(15, 0));
            else
               col = COLUMN_W'($urandom_range(n - 1, 0));
            offer_column(col, ASK_PREDICTED, '0, 1'b0);
         end
      end
      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d requests (%0d off the board), %0d answers checked",
               columns_sent, off_board_sent, answers_checked);
      $display("board sizes 0 to 12 with random stalls and a %0d-cycle receiver hold-off",
               HOLD_CYCLES);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/nqsc_pkg.sv
hw/rtl/nqsc_search.sv
hw/rtl/n_queens_solution_counter.sv
verif/tb_top.sv
